// File: design/smsa_pkg.sv
// ----------------------------------------------------------------------------
// Sliding median spike alert package
// Item types, command and status bundles and fixed constants shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package smsa_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 8;
  localparam int CFG_W    = 9;
  localparam int ALERT_W  = 16;

  // Window length after reset.
  localparam logic [CFG_W-1:0]   WINDOW_LEN_RESET = 9'd5;
  // Saturation value of the alert count.
  localparam logic [ALERT_W-1:0] ALERT_MAX        = 16'hFFFF;

  // One input item.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic               primed;
    logic               alert;
    logic [ALERT_W-1:0] alert_total;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic dec_rd;
    logic dec_wr;
    logic inc_rd;
    logic inc_wr;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic primed;
    logic median_found;
  } dp_status_t;

endpackage

// File: design/smsa_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding median spike alert controller
// Sequences one item through median scan, histogram update and result
// hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module smsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output smsa_pkg::dp_cmd_t    cmd,
  input  smsa_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DEC_RD,
    S_DEC_WR,
    S_INC_RD,
    S_INC_WR,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // An item is taken only between items.
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.primed ? S_SCAN : S_INC_RD;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.median_found) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_DEC_RD;
      end
      S_DEC_RD: begin
        cmd.dec_rd = 1'b1;
        state_nxt  = S_DEC_WR;
      end
      S_DEC_WR: begin
        cmd.dec_wr = 1'b1;
        state_nxt  = S_INC_RD;
      end
      S_INC_RD: begin
        cmd.inc_rd = 1'b1;
        state_nxt  = S_INC_WR;
      end
      S_INC_WR: begin
        cmd.inc_wr = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new result never overwrites one that is still held.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result emitted over a stalled result");

  // An accepted item closes the input until its work is done.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accepting an item");

  // The threshold is only used after the scan has found the median.
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> status.median_found)
    else $error("decision taken before the median was found");

endmodule

// File: design/smsa_datapath.sv
// ----------------------------------------------------------------------------
// Sliding median spike alert datapath
// Holds the histogram and sample ring memories, the window bookkeeping,
// the median scan and the alert counter, driven by controller commands.
// ----------------------------------------------------------------------------
module smsa_datapath #(
  parameter int WINDOW_MAX = 256,
  parameter int VALUE_BINS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [smsa_pkg::CFG_W-1:0]           cfg_wdata,
  input  smsa_pkg::in_item_t                   in_item,
  input  smsa_pkg::dp_cmd_t                    cmd,
  output smsa_pkg::dp_status_t                 status,
  output smsa_pkg::out_item_t                  out_item
);

  // Only bins that an 8-bit sample can reach are stored.
  localparam int SAMPLE_SPAN = 1 << smsa_pkg::SAMPLE_W;
  localparam int BIN_USED    = (VALUE_BINS < SAMPLE_SPAN) ? VALUE_BINS : SAMPLE_SPAN;
  localparam int BIN_AW      = $clog2(BIN_USED);
  localparam int RING_AW     = $clog2(WINDOW_MAX);
  localparam int FILL_W      = $clog2(WINDOW_MAX + 1);
  localparam int SW          = smsa_pkg::SAMPLE_W;

  // Configuration and sequence state.
  logic [smsa_pkg::CFG_W-1:0]   win_len_r;
  logic [RING_AW-1:0]           ptr_r;
  logic [FILL_W-1:0]            fill_r;
  logic [smsa_pkg::ALERT_W-1:0] alert_cnt_r;
  logic [BIN_USED-1:0]          bin_vld_r;

  // Scan state.
  logic [BIN_AW-1:0] scan_addr_r;
  logic [BIN_AW-1:0] data_addr_r;
  logic              scan_vld_r;
  logic [FILL_W-1:0] cum_r;
  logic              lo_found_r;
  logic              hi_found_r;
  logic [SW-1:0]     v_lo_r;
  logic [SW-1:0]     v_hi_r;

  // Item payload.
  logic [SW-1:0]       sample_r;
  logic                last_r;
  logic                primed_r;
  logic                alert_r;
  logic [BIN_AW-1:0]   ov_addr_r;
  smsa_pkg::out_item_t out_item_r;

  // Memories and their registered read data.
  logic [FILL_W-1:0] bin_mem [BIN_USED];
  logic [SW-1:0]     ring_mem [WINDOW_MAX];
  logic [FILL_W-1:0] bin_q;
  logic              bin_rd_vld_q;
  logic [SW-1:0]     ring_q;

  // Combinational values.
  logic [FILL_W-1:0] w_eff;
  logic [FILL_W-1:0] rank_lo;
  logic [FILL_W-1:0] rank_hi;
  logic [SW-1:0]     sample_sat;
  logic [BIN_AW-1:0] sample_addr;
  logic [BIN_AW-1:0] bin_rd_addr;
  logic [BIN_AW-1:0] bin_wr_addr;
  logic              bin_we;
  logic [FILL_W-1:0] bin_cnt;
  logic [FILL_W-1:0] bin_wd;
  logic [FILL_W-1:0] cum_sum;
  logic [FILL_W-1:0] fill_mod;
  logic [FILL_W-1:0] ptr_ext;
  logic [FILL_W-1:0] old_lin;
  logic [RING_AW-1:0] oldest_addr;
  logic [SW:0]       threshold;
  logic              hit;
  logic              clear_seq;

  // Effective window length, clamped to one and to the ring depth.
  always_comb begin
    if (win_len_r == '0) begin
      w_eff = FILL_W'(1);
    end else if (int'(win_len_r) > WINDOW_MAX) begin
      w_eff = FILL_W'(WINDOW_MAX);
    end else begin
      w_eff = FILL_W'(win_len_r);
    end
  end

  // Ranks of the two middle values; they coincide for an odd window.
  assign rank_hi = w_eff >> 1;
  assign rank_lo = (w_eff - FILL_W'(1)) >> 1;

  // Samples beyond the last bin land in the last bin.
  always_comb begin
    if (int'(in_item.sample) >= BIN_USED) begin
      sample_sat = SW'(BIN_USED - 1);
    end else begin
      sample_sat = in_item.sample;
    end
  end
  assign sample_addr = BIN_AW'(sample_r);

  // Ring slot of the oldest sample in the window.
  assign fill_mod    = (fill_r == FILL_W'(WINDOW_MAX)) ? '0 : fill_r;
  assign ptr_ext     = FILL_W'(ptr_r);
  assign old_lin     = (ptr_ext >= fill_mod) ? (ptr_ext - fill_mod)
                                             : (ptr_ext + FILL_W'(WINDOW_MAX) - fill_mod);
  assign oldest_addr = RING_AW'(old_lin);

  // Histogram port selection: scan, remove oldest, add newest.
  always_comb begin
    if (cmd.dec_rd) begin
      bin_rd_addr = BIN_AW'(ring_q);
    end else if (cmd.inc_rd) begin
      bin_rd_addr = sample_addr;
    end else begin
      bin_rd_addr = scan_addr_r;
    end
  end
  assign bin_cnt     = bin_rd_vld_q ? bin_q : '0;
  assign bin_we      = cmd.dec_wr | cmd.inc_wr;
  assign bin_wr_addr = cmd.dec_wr ? ov_addr_r : sample_addr;
  assign bin_wd      = cmd.dec_wr ? (bin_cnt - FILL_W'(1)) : (bin_cnt + FILL_W'(1));

  // Running count of samples at or below the bin being scanned.
  assign cum_sum = cum_r + bin_cnt;

  // Twice the median, or the sum of the two middle values.
  assign threshold = {1'b0, v_lo_r} + {1'b0, v_hi_r};
  assign hit       = ({1'b0, sample_r} >= threshold);

  // A register write or the end of a sequence starts a fresh window.
  assign clear_seq = cfg_we | (cmd.emit & last_r);

  // Histogram memory.
  always_ff @(posedge clk) begin
    bin_q        <= bin_mem[bin_rd_addr];
    bin_rd_vld_q <= bin_vld_r[bin_rd_addr];
    if (bin_we) begin
      bin_mem[bin_wr_addr] <= bin_wd;
    end
  end

  // Sample ring memory.
  always_ff @(posedge clk) begin
    ring_q <= ring_mem[oldest_addr];
    if (cmd.inc_wr) begin
      ring_mem[ptr_r] <= sample_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= smsa_pkg::WINDOW_LEN_RESET;
      ptr_r       <= '0;
      fill_r      <= '0;
      alert_cnt_r <= '0;
      bin_vld_r   <= '0;
      scan_addr_r <= '0;
      scan_vld_r  <= 1'b0;
      cum_r       <= '0;
      lo_found_r  <= 1'b0;
      hi_found_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_len_r <= cfg_wdata;
      end

      // Median scan over the bins, one bin a cycle.
      if (cmd.load) begin
        scan_addr_r <= '0;
        scan_vld_r  <= 1'b0;
        cum_r       <= '0;
        lo_found_r  <= 1'b0;
        hi_found_r  <= 1'b0;
      end else if (cmd.scan && !hi_found_r) begin
        scan_vld_r <= 1'b1;
        if (scan_addr_r != BIN_AW'(BIN_USED - 1)) begin
          scan_addr_r <= scan_addr_r + BIN_AW'(1);
        end
        if (scan_vld_r) begin
          cum_r <= cum_sum;
          if (!lo_found_r && (cum_sum > rank_lo)) begin
            lo_found_r <= 1'b1;
          end
          if (cum_sum > rank_hi) begin
            hi_found_r <= 1'b1;
          end
        end
      end

      // Saturating alert count.
      if (cmd.decide && hit && (alert_cnt_r != smsa_pkg::ALERT_MAX)) begin
        alert_cnt_r <= alert_cnt_r + smsa_pkg::ALERT_W'(1);
      end

      // The new sample enters the ring.
      if (cmd.inc_wr) begin
        if (ptr_r == RING_AW'(WINDOW_MAX - 1)) begin
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + RING_AW'(1);
        end
        if (!primed_r) begin
          fill_r <= fill_r + FILL_W'(1);
        end
      end

      // Bin occupancy flags.
      if (bin_we) begin
        bin_vld_r[bin_wr_addr] <= 1'b1;
      end

      if (clear_seq) begin
        ptr_r       <= '0;
        fill_r      <= '0;
        alert_cnt_r <= '0;
        bin_vld_r   <= '0;
      end
    end
  end

  // Item payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample_sat;
      last_r   <= in_item.last_sample;
      primed_r <= status.primed;
      alert_r  <= 1'b0;
    end
    if (cmd.scan && !hi_found_r) begin
      data_addr_r <= scan_addr_r;
      if (scan_vld_r && !lo_found_r && (cum_sum > rank_lo)) begin
        v_lo_r <= SW'(data_addr_r);
      end
      if (scan_vld_r && (cum_sum > rank_hi)) begin
        v_hi_r <= SW'(data_addr_r);
      end
    end
    if (cmd.decide) begin
      alert_r <= hit;
    end
    if (cmd.dec_rd) begin
      ov_addr_r <= BIN_AW'(ring_q);
    end
    if (cmd.emit) begin
      out_item_r.primed      <= primed_r;
      out_item_r.alert       <= alert_r;
      out_item_r.alert_total <= alert_cnt_r;
    end
  end

  assign status.primed       = (fill_r >= w_eff);
  assign status.median_found = hi_found_r;
  assign out_item            = out_item_r;

  // The window never holds more samples than its length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count exceeds window length");

  // The oldest sample is always present in the histogram when removed.
  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_wr |-> (bin_rd_vld_q && (bin_q != '0)))
    else $error("removing a sample from an empty bin");

  // The lower middle value is found no later than the upper one.
  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && hi_found_r) |-> (lo_found_r && (v_lo_r <= v_hi_r)))
    else $error("middle values out of order");

endmodule

// File: design/sliding_median_spike_alert_core.sv
// Sequence: while the window is still filling, an accepted item has its bin read and
// incremented, then its result is handed over; once it is full, the median scan runs up
// to the bin of the upper middle value, then the decision, the oldest sample's removal,
// the new sample's bin update and the hand-off. Flow: one item at a time; the next item
// can be taken in the cycle after the hand-off; a stalled result holds the input off.
// Reset: synchronous, active low; the histogram is emptied through per-bin valid flags
// in the reset cycle, with no clearing pass, and the window length returns to 5.
// ----------------------------------------------------------------------------
// Sliding median spike alert core
// Flags samples that reach twice the median of a sliding window, using a
// histogram scanned by a controller and datapath pair.
// ----------------------------------------------------------------------------
module sliding_median_spike_alert_core #(
  parameter int WINDOW_MAX = 256,
  parameter int VALUE_BINS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [smsa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  smsa_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output smsa_pkg::out_item_t        out_item
);

  smsa_pkg::dp_cmd_t    cmd;
  smsa_pkg::dp_status_t status;

  // Sequencer for one item at a time.
  smsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Histogram, ring and counters.
  smsa_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .VALUE_BINS (VALUE_BINS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

// File: bench/tb_sliding_median_spike_alert_core.sv
// ----------------------------------------------------------------------------
// Sliding median spike alert core testbench
// Drives samples through the valid/stall input channel and checks every
// verdict against a histogram model kept in the bench. It covers the default
// window, directed edge cases, a long receiver hold-off, and random sequences
// over many window settings.
// ----------------------------------------------------------------------------
module tb_sliding_median_spike_alert_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 5;
  localparam int BINS          = 256;
  localparam int WIN_MAX       = 256;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 800;
  localparam int TAIL_CYCLES   = 300;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [smsa_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  smsa_pkg::in_item_t         in_item   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  smsa_pkg::out_item_t        out_item;

  // Idle rates in percent and the long receiver hold-off.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic recv_hold     = 1'b0;

  int                  fail_count = 0;
  smsa_pkg::out_item_t pending_verdicts[$];

  // Bench copy of the block state.
  logic [smsa_pkg::CFG_W-1:0]    window_reg;
  logic [8:0]                    hist_bins [BINS];
  logic [smsa_pkg::SAMPLE_W-1:0] recent_samples [WIN_MAX];
  logic [7:0]                    write_slot;
  int unsigned                   held_count;
  logic [smsa_pkg::ALERT_W-1:0]  alert_tally;

  sliding_median_spike_alert_core #(
    .WINDOW_MAX(WIN_MAX),
    .VALUE_BINS(BINS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #CLK_HALF clk = ~clk;

  // Empty the histogram and restart the sequence.
  function automatic void clear_sequence_state();
    for (int i = 0; i < BINS; i++) begin
      hist_bins[i] = '0;
    end
    for (int i = 0; i < WIN_MAX; i++) begin
      recent_samples[i] = '0;
    end
    write_slot  = '0;
    held_count  = 0;
    alert_tally = '0;
  endfunction

  function automatic int unsigned effective_window(logic [smsa_pkg::CFG_W-1:0] len);
    if (len == 0) begin
      return 1;
    end
    return (len > WIN_MAX) ? WIN_MAX : len;
  endfunction

  // Value found at a zero-based rank of the sorted window.
  function automatic int unsigned value_at(int unsigned rank);
    int unsigned cum;
    cum = 0;
    for (int v = 0; v < BINS; v++) begin
      cum += hist_bins[v];
      if (cum > rank) begin
        return v;
      end
    end
    return BINS - 1;
  endfunction

  // Compute the verdict for one sample and advance the bench state.
  function automatic smsa_pkg::out_item_t predict_verdict(smsa_pkg::in_item_t it);
    int unsigned         win;
    int unsigned         thresh;
    int unsigned         oldest;
    smsa_pkg::out_item_t v;
    win = effective_window(window_reg);
    v   = '0;
    if (held_count >= win) begin
      v.primed = 1'b1;
      if (win % 2 == 1) begin
        thresh = 2 * value_at((win - 1) / 2);
      end else begin
        thresh = value_at(win / 2 - 1) + value_at(win / 2);
      end
      if (it.sample >= thresh) begin
        v.alert = 1'b1;
        if (alert_tally != smsa_pkg::ALERT_MAX) begin
          alert_tally++;
        end
      end
      // The oldest sample leaves the window after the comparison.
      oldest = (write_slot + WIN_MAX - (held_count % WIN_MAX)) % WIN_MAX;
      if (hist_bins[recent_samples[oldest]] != 0) begin
        hist_bins[recent_samples[oldest]]--;
      end
      held_count--;
    end
    recent_samples[write_slot] = it.sample;
    hist_bins[it.sample]++;
    write_slot++;
    held_count++;
    v.alert_total = alert_tally;
    if (it.last_sample) begin
      clear_sequence_state();
    end
    return v;
  endfunction

  // Offer one item after a random gap and record its verdict once accepted.
  task automatic send_item(input logic [smsa_pkg::SAMPLE_W-1:0] sample, input logic last);
    smsa_pkg::in_item_t it;
    it.sample      = sample;
    it.last_sample = last;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_verdicts.push_back(predict_verdict(it));
  endtask

  // Stop offering items and wait until every verdict has come back.
  task automatic wait_all_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the window length once the block has gone quiet.
  task automatic write_window(input logic [smsa_pkg::CFG_W-1:0] len);
    wait_all_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_reg  = len;
    clear_sequence_state();
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Mostly a low baseline with zeros and spikes, sometimes the full range.
  function automatic logic [smsa_pkg::SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return '0;
    end else if (r < 75) begin
      return smsa_pkg::SAMPLE_W'($urandom_range(40, 1));
    end else if (r < 92) begin
      return smsa_pkg::SAMPLE_W'($urandom_range(255, 60));
    end
    return smsa_pkg::SAMPLE_W'($urandom_range(255, 0));
  endfunction

  // Sequence length: usually long enough to prime, sometimes cut short.
  function automatic int sequence_length(int unsigned win);
    if ($urandom_range(99) < 12) begin
      return $urandom_range(win, 1);
    end
    return win + $urandom_range((win >= 200) ? 60 : 3 * win + 10, 1);
  endfunction

  // The default window of five applies straight after reset.
  task automatic test_reset_window();
    send_item(8'd1, 1'b0);
    send_item(8'd2, 1'b0);
    send_item(8'd3, 1'b0);
    send_item(8'd4, 1'b0);
    send_item(8'd5, 1'b0);
    send_item(8'd6, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b1);
  endtask

  // Thresholds at their edges, window zero, an even window and an early end.
  task automatic test_directed_windows();
    write_window(9'd1);
    send_item(8'd0, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd128, 1'b0);
    send_item(8'd255, 1'b1);
    write_window(9'd0);
    send_item(8'd7, 1'b0);
    send_item(8'd14, 1'b0);
    send_item(8'd13, 1'b1);
    write_window(9'd2);
    send_item(8'd10, 1'b0);
    send_item(8'd20, 1'b0);
    send_item(8'd30, 1'b0);
    send_item(8'd44, 1'b0);
    send_item(8'd50, 1'b1);
    write_window(9'd3);
    send_item(8'd100, 1'b0);
    send_item(8'd1, 1'b1);
    send_item(8'd5, 1'b0);
    send_item(8'd5, 1'b0);
    send_item(8'd5, 1'b0);
    send_item(8'd10, 1'b0);
    send_item(8'd9, 1'b1);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    write_window(9'd3);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    for (int n = 0; n < 40; n++) begin
      send_item(pick_sample(), n == 39);
    end
  endtask

  // Random sequences over a spread of window settings and idle patterns.
  task automatic test_random_sequences();
    logic [smsa_pkg::CFG_W-1:0] lens [9] = '{9'd3, 9'd1, 9'd2, 9'd256, 9'd7, 9'd0,
                                             9'd511, 9'd16, 9'd4};
    int               counts [9] = '{120, 100, 120, 260, 120, 80, 260, 120, 100};
    int               seq_len;
    int               target;
    int unsigned      win;
    logic             last;
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        set_idle(15, 60);
      end else if (p < 6) begin
        set_idle(60, 15);
      end else begin
        set_idle(0, 0);
      end
      write_window(lens[p]);
      win     = effective_window(lens[p]);
      seq_len = 0;
      target  = sequence_length(win);
      for (int n = 0; n < counts[p]; n++) begin
        seq_len++;
        last = (seq_len >= target);
        send_item(pick_sample(), last);
        if (last) begin
          seq_len = 0;
          target  = sequence_length(win);
        end
      end
    end
  endtask

  // Receiver side: random stall, forced high during the hold-off.
  always @(posedge clk) begin
    out_stall <= recv_hold || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted verdict with the oldest prediction.
  always @(posedge clk) begin
    smsa_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t ns: unexpected item, expected none, actual %p", $time, out_item);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("primed", want.primed, out_item.primed);
        check_field("alert", want.alert, out_item.alert);
        check_field("alert_total", want.alert_total, out_item.alert_total);
      end
    end
  end

  // Test sequence.
  initial begin
    window_reg = smsa_pkg::WINDOW_LEN_RESET;
    clear_sequence_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idle(15, 60);
    test_reset_window();
    test_directed_windows();
    test_output_backpressure();
    test_random_sequences();
    wait_all_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
